FILE: hdl/sha256_pkg.sv
package sha256_pkg;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PAD,
    ST_LEN,
    ST_COMP,
    ST_ADD,
    ST_EMIT
  } state_t;

  // controller -> datapath
  typedef struct packed {
    logic       load_byte;   // write byte at current position, count it
    logic       count_len;   // add 8 to bit length
    logic [7:0] byte_val;
    logic       put_len;     // write bit length into words 14 and 15
    logic       comp_start;  // load working words from hash words
    logic       round_en;    // one round
    logic       comp_done;   // add working words into hash words
    logic       msg_reset;   // back to initial state
  } dp_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic [5:0] pos;
    logic [5:0] round;
  } dp_sts_t;

  localparam logic [31:0] ROUND_K [64] = '{
    32'h428a2f98,32'h71374491,32'hb5c0fbcf,32'he9b5dba5,32'h3956c25b,32'h59f111f1,
    32'h923f82a4,32'hab1c5ed5,32'hd807aa98,32'h12835b01,32'h243185be,32'h550c7dc3,
    32'h72be5d74,32'h80deb1fe,32'h9bdc06a7,32'hc19bf174,32'he49b69c1,32'hefbe4786,
    32'h0fc19dc6,32'h240ca1cc,32'h2de92c6f,32'h4a7484aa,32'h5cb0a9dc,32'h76f988da,
    32'h983e5152,32'ha831c66d,32'hb00327c8,32'hbf597fc7,32'hc6e00bf3,32'hd5a79147,
    32'h06ca6351,32'h14292967,32'h27b70a85,32'h2e1b2138,32'h4d2c6dfc,32'h53380d13,
    32'h650a7354,32'h766a0abb,32'h81c2c92e,32'h92722c85,32'ha2bfe8a1,32'ha81a664b,
    32'hc24b8b70,32'hc76c51a3,32'hd192e819,32'hd6990624,32'hf40e3585,32'h106aa070,
    32'h19a4c116,32'h1e376c08,32'h2748774c,32'h34b0bcb5,32'h391c0cb3,32'h4ed8aa4a,
    32'h5b9cca4f,32'h682e6ff3,32'h748f82ee,32'h78a5636f,32'h84c87814,32'h8cc70208,
    32'h90befffa,32'ha4506ceb,32'hbef9a3f7,32'hc67178f2
  };

  localparam logic [31:0] INIT_HASH [8] = '{
    32'h6a09e667,32'hbb67ae85,32'h3c6ef372,32'ha54ff53a,
    32'h510e527f,32'h9b05688c,32'h1f83d9ab,32'h5be0cd19
  };

  localparam logic [7:0] PAD_BYTE    = 8'h80;
  localparam logic [5:0] LEN_POS     = 6'd56;
  localparam logic [5:0] PAD_END_POS = 6'd55;
  localparam logic [5:0] LAST_POS    = 6'd63;
  localparam logic [5:0] LAST_ROUND  = 6'd63;
  localparam logic [2:0] LAST_IDX    = 3'd7;

endpackage

FILE: hdl/sha256_message_digest.sv
// channel | dir | tdata fields (low bit up)                     | tuser | tlast
// in_     | in  | has_byte[0], data_byte[8:1]                   | -     | end_of_message
// out_    | out | digest_word[31:0], word_index[34:32], pad zero | -     | last_word
// The byte that fills a block holds off input while the single round unit runs 64
// rounds and the working words are added into the hash.
// End of message: padding bytes one a cycle up to byte 55 (with 56 or more bytes held,
// through byte 63, a compression, then zeros from byte 0), the length, a compression,
// then eight output transactions.
// Reset is synchronous, active low, and restores the initial hash values.
// Input is ready only while idle; out_tready low stalls the output words.
module sha256_message_digest (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // has_byte, data_byte
  input  logic        in_tlast,   // end_of_message
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,  // digest_word, word_index
  output logic        out_tlast   // last_word
);

  sha256_pkg::dp_cmd_t cmd;
  sha256_pkg::dp_sts_t sts;
  logic [31:0] hash [8];
  logic [2:0]  idx;

  sha256_ctrl u_ctrl (
    .clk, .rst_n, .in_tvalid, .in_tready,
    .in_tdata({in_tlast, in_tdata[8:0]}),
    .out_tvalid, .out_tready, .out_idx(idx), .cmd, .sts
  );

  sha256_datapath u_dp (.clk, .rst_n, .cmd, .sts, .hash_out(hash));

  assign out_tdata = {5'd0, idx, hash[idx]};
  assign out_tlast = idx == sha256_pkg::LAST_IDX;

  a_idle_ready: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !in_tready) else $error("input ready while emitting");
  a_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tready && out_tlast |=> !out_tvalid)
    else $error("output after last word");
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("output changed while stalled");

endmodule

FILE: hdl/sha256_datapath.sv
module sha256_datapath (
  input  logic                clk,
  input  logic                rst_n,
  input  sha256_pkg::dp_cmd_t cmd,
  output sha256_pkg::dp_sts_t sts,
  output logic [31:0]         hash_out [8]
);

  logic [31:0] hash_r [8];
  logic [31:0] hash_nxt [8];
  logic [31:0] blk_r [16];   // rolling schedule window
  logic [31:0] wv_r [8];
  logic [31:0] wv_nxt [8];
  logic [5:0]  pos_r, pos_nxt;
  logic [5:0]  rnd_r, rnd_nxt;
  logic [63:0] len_r, len_nxt;

  logic [31:0] s0, s1, w_new, t1, t2, ch, mj, e1, a0;
  logic [3:0]  widx;
  logic [4:0]  sh;

  assign widx = pos_r[5:2];
  // big-endian byte lane: (3 - pos[1:0]) * 8
  assign sh   = {~pos_r[1:0], 3'b000};

  always_comb begin
    s0 = {blk_r[1][6:0], blk_r[1][31:7]} ^ {blk_r[1][17:0], blk_r[1][31:18]}
         ^ (blk_r[1] >> 3);
    s1 = {blk_r[14][16:0], blk_r[14][31:17]} ^ {blk_r[14][18:0], blk_r[14][31:19]}
         ^ (blk_r[14] >> 10);
    w_new = s1 + blk_r[9] + s0 + blk_r[0];
    e1 = {wv_r[4][5:0], wv_r[4][31:6]} ^ {wv_r[4][10:0], wv_r[4][31:11]}
         ^ {wv_r[4][24:0], wv_r[4][31:25]};
    a0 = {wv_r[0][1:0], wv_r[0][31:2]} ^ {wv_r[0][12:0], wv_r[0][31:13]}
         ^ {wv_r[0][21:0], wv_r[0][31:22]};
    ch = (wv_r[4] & wv_r[5]) ^ (~wv_r[4] & wv_r[6]);
    mj = (wv_r[0] & wv_r[1]) ^ (wv_r[0] & wv_r[2]) ^ (wv_r[1] & wv_r[2]);
    t1 = wv_r[7] + e1 + ch + sha256_pkg::ROUND_K[rnd_r] + blk_r[0];
    t2 = a0 + mj;
  end

  always_comb begin
    pos_nxt  = pos_r;
    rnd_nxt  = rnd_r;
    len_nxt  = len_r;
    hash_nxt = hash_r;
    wv_nxt   = wv_r;
    if (cmd.load_byte) pos_nxt = pos_r + 6'd1;
    if (cmd.count_len) len_nxt = len_r + 64'd8;
    if (cmd.comp_start) begin
      wv_nxt  = hash_r;
      rnd_nxt = '0;
    end
    if (cmd.round_en) begin
      wv_nxt[7] = wv_r[6];
      wv_nxt[6] = wv_r[5];
      wv_nxt[5] = wv_r[4];
      wv_nxt[4] = wv_r[3] + t1;
      wv_nxt[3] = wv_r[2];
      wv_nxt[2] = wv_r[1];
      wv_nxt[1] = wv_r[0];
      wv_nxt[0] = t1 + t2;
      rnd_nxt   = rnd_r + 6'd1;
    end
    if (cmd.comp_done) begin
      for (int i = 0; i < 8; i++) hash_nxt[i] = hash_r[i] + wv_r[i];
    end
    if (cmd.msg_reset) begin
      hash_nxt = sha256_pkg::INIT_HASH;
      len_nxt  = '0;
      pos_nxt  = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hash_r <= sha256_pkg::INIT_HASH;
      pos_r  <= '0;
      rnd_r  <= '0;
      len_r  <= '0;
    end else begin
      hash_r <= hash_nxt;
      pos_r  <= pos_nxt;
      rnd_r  <= rnd_nxt;
      len_r  <= len_nxt;
    end
  end

  always_ff @(posedge clk) begin
    wv_r <= wv_nxt;
    if (cmd.round_en) begin
      for (int i = 0; i < 15; i++) blk_r[i] <= blk_r[i + 1];
      blk_r[15] <= w_new;
    end else if (cmd.put_len) begin
      blk_r[14] <= len_r[63:32];
      blk_r[15] <= len_r[31:0];
    end else if (cmd.load_byte) begin
      blk_r[widx] <= (blk_r[widx] & ~(32'hff << sh)) | ({24'd0, cmd.byte_val} << sh);
    end
  end

  assign sts.pos   = pos_r;
  assign sts.round = rnd_r;
  assign hash_out  = hash_r;

endmodule

FILE: hdl/sha256_ctrl.sv
module sha256_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_tvalid,
  output logic                in_tready,
  input  logic [9:0]          in_tdata,
  output logic                out_tvalid,
  input  logic                out_tready,
  output logic [2:0]          out_idx,
  output sha256_pkg::dp_cmd_t cmd,
  input  sha256_pkg::dp_sts_t sts
);

  sha256_pkg::state_t state_r, state_nxt;
  sha256_pkg::state_t ret_r, ret_nxt;   // where to go after compression
  logic [2:0] idx_r, idx_nxt;
  logic       pad_first_r, pad_first_nxt;   // next pad byte is 0x80
  logic       acc;
  logic       has, eom;

  assign has       = in_tdata[0];
  assign eom       = in_tdata[9];
  assign in_tready = state_r == sha256_pkg::ST_IDLE;
  assign acc       = in_tvalid && in_tready;

  always_comb begin
    state_nxt     = state_r;
    ret_nxt       = ret_r;
    idx_nxt       = idx_r;
    pad_first_nxt = pad_first_r;
    unique case (state_r)
      sha256_pkg::ST_IDLE: begin
        if (acc) begin
          if (eom) pad_first_nxt = 1'b1;
          if (has && sts.pos == sha256_pkg::LAST_POS) begin
            state_nxt = sha256_pkg::ST_COMP;
            ret_nxt   = eom ? sha256_pkg::ST_PAD : sha256_pkg::ST_IDLE;
          end else if (eom) begin
            state_nxt = sha256_pkg::ST_PAD;
          end
        end
      end
      sha256_pkg::ST_PAD: begin
        // 0x80 then zeros up to the length field, may spill a block
        pad_first_nxt = 1'b0;
        if (sts.pos == sha256_pkg::LAST_POS) begin
          state_nxt = sha256_pkg::ST_COMP;
          ret_nxt   = sha256_pkg::ST_PAD;
        end else if (sts.pos == sha256_pkg::PAD_END_POS) begin
          state_nxt = sha256_pkg::ST_LEN;
        end
      end
      sha256_pkg::ST_LEN: begin
        state_nxt = sha256_pkg::ST_COMP;
        ret_nxt   = sha256_pkg::ST_EMIT;
        idx_nxt   = '0;
      end
      sha256_pkg::ST_COMP: begin
        if (sts.round == sha256_pkg::LAST_ROUND) state_nxt = sha256_pkg::ST_ADD;
      end
      sha256_pkg::ST_ADD: begin
        state_nxt = ret_r;
      end
      sha256_pkg::ST_EMIT: begin
        if (out_tready) begin
          idx_nxt = idx_r + 3'd1;
          if (idx_r == sha256_pkg::LAST_IDX) state_nxt = sha256_pkg::ST_IDLE;
        end
      end
      default: state_nxt = sha256_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd        = '0;
    out_tvalid = 1'b0;
    out_idx    = idx_r;
    unique case (state_r)
      sha256_pkg::ST_IDLE: begin
        cmd.load_byte  = in_tvalid && has;
        cmd.count_len  = in_tvalid && has;
        cmd.byte_val   = in_tdata[8:1];
        cmd.comp_start = in_tvalid && has && sts.pos == sha256_pkg::LAST_POS;
      end
      sha256_pkg::ST_PAD: begin
        cmd.load_byte  = 1'b1;
        cmd.byte_val   = pad_first_r ? sha256_pkg::PAD_BYTE : 8'd0;
        cmd.comp_start = sts.pos == sha256_pkg::LAST_POS;
      end
      sha256_pkg::ST_LEN: begin
        // length words fill bytes 56..63 directly
        cmd.put_len    = 1'b1;
        cmd.comp_start = 1'b1;
      end
      sha256_pkg::ST_COMP: begin
        cmd.round_en = 1'b1;
      end
      sha256_pkg::ST_ADD: begin
        cmd.comp_done = 1'b1;
      end
      sha256_pkg::ST_EMIT: begin
        out_tvalid    = 1'b1;
        cmd.msg_reset = out_tready && idx_r == sha256_pkg::LAST_IDX;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= sha256_pkg::ST_IDLE;
      ret_r       <= sha256_pkg::ST_IDLE;
      idx_r       <= '0;
      pad_first_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      ret_r       <= ret_nxt;
      idx_r       <= idx_nxt;
      pad_first_r <= pad_first_nxt;
    end
  end

endmodule

FILE: tb/tb_sha256_message_digest.sv
`timescale 1ns / 1ps

module tb_sha256_message_digest;

  typedef struct packed {
    logic [31:0] word;
    logic [2:0]  idx;
    logic        last;
  } digest_word_t;

  typedef struct {
    logic       has_byte;
    logic [7:0] data_byte;
    logic       eom;
    logic       check_fixed;   // compare against the typed-in digest below
    logic [31:0] fixed_w0;     // first digest word, known value
  } stim_row_t;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [15:0] in_tdata;
  logic        in_tlast;
  logic        out_tvalid;
  logic        out_tready;
  logic [39:0] out_tdata;
  logic        out_tlast;

  sha256_message_digest dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready),
    .in_tdata(in_tdata), .in_tlast(in_tlast),
    .out_tvalid(out_tvalid), .out_tready(out_tready),
    .out_tdata(out_tdata), .out_tlast(out_tlast)
  );

  // predictor state
  logic [31:0] h_st [8];
  logic [31:0] blk [16];
  int unsigned fill;
  logic [63:0] bit_len;

  digest_word_t digest_q [$];
  logic [31:0]  w0_known_q [$];
  int unsigned  mismatches;
  int unsigned  items_sent;
  bit           idle_en;

  function automatic logic [31:0] ror(logic [31:0] x, int n);
    return (x >> n) | (x << (32 - n));
  endfunction

  task automatic sha_compress();
    logic [31:0] w [64];
    logic [31:0] a, b, c, d, e, f, g, h, t1, t2;
    for (int i = 0; i < 16; i++) w[i] = blk[i];
    for (int i = 16; i < 64; i++)
      w[i] = (ror(w[i-2], 17) ^ ror(w[i-2], 19) ^ (w[i-2] >> 10)) + w[i-7] +
             (ror(w[i-15], 7) ^ ror(w[i-15], 18) ^ (w[i-15] >> 3)) + w[i-16];
    a = h_st[0]; b = h_st[1]; c = h_st[2]; d = h_st[3];
    e = h_st[4]; f = h_st[5]; g = h_st[6]; h = h_st[7];
    for (int i = 0; i < 64; i++) begin
      t1 = h + (ror(e, 6) ^ ror(e, 11) ^ ror(e, 25)) + ((e & f) ^ (~e & g)) +
           sha256_pkg::ROUND_K[i] + w[i];
      t2 = (ror(a, 2) ^ ror(a, 13) ^ ror(a, 22)) + ((a & b) ^ (a & c) ^ (b & c));
      h = g; g = f; f = e; e = d + t1; d = c; c = b; b = a; a = t1 + t2;
    end
    h_st[0] += a; h_st[1] += b; h_st[2] += c; h_st[3] += d;
    h_st[4] += e; h_st[5] += f; h_st[6] += g; h_st[7] += h;
  endtask

  task automatic msg_init();
    for (int i = 0; i < 8; i++) h_st[i] = sha256_pkg::INIT_HASH[i];
    for (int i = 0; i < 16; i++) blk[i] = '0;
    fill = 0;
    bit_len = '0;
  endtask

  task automatic append_byte(logic [7:0] b);
    blk[fill / 4][(3 - fill % 4) * 8 +: 8] = b;
    fill++;
    if (fill == 64) begin
      sha_compress();
      fill = 0;
    end
  endtask

  task automatic predict_digest(logic has, logic [7:0] b, logic eom);
    logic [63:0] len;
    digest_word_t r;
    if (has) begin
      append_byte(b);
      bit_len += 64'd8;
    end
    if (!eom) return;
    len = bit_len;
    append_byte(sha256_pkg::PAD_BYTE);
    while (fill != sha256_pkg::LEN_POS) append_byte(8'h00);
    for (int i = 0; i < 8; i++) append_byte(len[(7 - i) * 8 +: 8]);
    for (int i = 0; i < 8; i++) begin
      r.word = h_st[i];
      r.idx  = i[2:0];
      r.last = (i == 7);
      digest_q.push_back(r);
    end
    msg_init();
  endtask

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // drive one transaction at the falling edge; in_tready only moves at the rising edge
  task automatic send_item(logic has, logic [7:0] b, logic eom);
    while (idle_en && $urandom_range(99) < 35) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {7'd0, b, has};
    in_tlast  <= eom;
    while (!in_tready) @(negedge clk);
    @(posedge clk);
    predict_digest(has, b, eom);
    items_sent++;
    @(negedge clk);
  endtask

  task automatic send_message(int unsigned nbytes, bit empty_tail);
    for (int i = 0; i < nbytes; i++)
      send_item(1'b1, 8'($urandom_range(255)), (i == nbytes - 1) && !empty_tail);
    if (empty_tail || nbytes == 0) send_item(1'b0, 8'($urandom_range(255)), 1'b1);
  endtask

  // output side: random stall, compare on accept
  always @(negedge clk) begin
    if (!rst_n) out_tready <= 1'b0;
    else out_tready <= !(idle_en && $urandom_range(99) < 35);
  end

  always @(posedge clk) begin
    digest_word_t got, exp_w;
    logic [31:0]  known_w;
    if (rst_n && out_tvalid && out_tready) begin
      got.word = out_tdata[31:0];
      got.idx  = out_tdata[34:32];
      got.last = out_tlast;
      if (digest_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected digest word %h", out_tdata);
      end else begin
        exp_w = digest_q.pop_front();
        if (got.idx == 3'd0 && w0_known_q.size() != 0) begin
          known_w = w0_known_q.pop_front();
          if (got.word !== known_w) begin
            mismatches++;
            if (mismatches <= 10)
              $display("known digest word 0: exp %h got %h", known_w, got.word);
          end
        end
        if (got !== exp_w || out_tdata[39:35] !== 5'd0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("digest mismatch: exp w=%h i=%0d l=%b got w=%h i=%0d l=%b",
                     exp_w.word, exp_w.idx, exp_w.last, got.word, got.idx, got.last);
        end
      end
    end
  end

  stim_row_t dir_rows [$];

  initial begin
    int n;
    clk = 1'b0;
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tlast = 1'b0;
    mismatches = 0;
    items_sent = 0;
    idle_en = 1'b1;
    msg_init();
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // empty message, then "abc", then idle no-byte items and extremes
    dir_rows.push_back('{1'b0, 8'h00, 1'b1, 1'b1, 32'he3b0c442});
    dir_rows.push_back('{1'b1, 8'h61, 1'b0, 1'b0, 32'h0});
    dir_rows.push_back('{1'b0, 8'hff, 1'b0, 1'b0, 32'h0});
    dir_rows.push_back('{1'b1, 8'h62, 1'b0, 1'b0, 32'h0});
    dir_rows.push_back('{1'b1, 8'h63, 1'b1, 1'b1, 32'hba7816bf});
    dir_rows.push_back('{1'b1, 8'hff, 1'b0, 1'b0, 32'h0});
    dir_rows.push_back('{1'b1, 8'h00, 1'b0, 1'b0, 32'h0});
    dir_rows.push_back('{1'b0, 8'haa, 1'b1, 1'b0, 32'h0});
    dir_rows.push_back('{1'b1, 8'h55, 1'b1, 1'b0, 32'h0});
    foreach (dir_rows[i]) begin
      if (dir_rows[i].check_fixed) w0_known_q.push_back(dir_rows[i].fixed_w0);
      send_item(dir_rows[i].has_byte, dir_rows[i].data_byte, dir_rows[i].eom);
    end

    // padding spill at 56 bytes; a full block with no gaps, ended on its last byte
    send_message(56, 0);
    idle_en = 1'b0;
    send_message(64, 0);
    idle_en = 1'b1;

    // random messages, mostly short
    while (items_sent < 160) begin
      if ($urandom_range(9) == 0) send_item(1'b0, 8'($urandom_range(255)), 1'b0);
      n = ($urandom_range(7) == 0) ? $urandom_range(30) : $urandom_range(12);
      send_message(n, $urandom_range(3) == 0);
    end
    in_tvalid <= 1'b0;

    while (digest_q.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (mismatches == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end

  initial begin
    #20ms;
    $display("FAIL");
    $finish;
  end

endmodule
